// ----- src/lsc_pkg.sv -----
// shared types and constants for the line sensor centroid block
// used by every module under src except lsc_ram; depends on nothing

package lsc_pkg;

   localparam int CHANNELS    = 8;
   localparam int SAMPLE_BITS = 12;

   // port widths fixed by the interface
   localparam int PORT_CHANNELS = 8;
   localparam int SAMPLE_W      = 12;
   localparam int WHITE_W       = 13;
   localparam int BLACK_W       = 12;
   localparam int THR_W         = 9;
   localparam int WEIGHTS_W     = 64;
   localparam int COUNT_W       = 4;
   localparam int ERROR_W       = 16;
   localparam int CSR_INDEX_W   = 1;

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W    = $clog2(CHANNELS + 1);
   localparam int SUM_W    = 8 + CH_IDX_W;
   localparam int DIV_W    = ((SUM_W + 8 + 1) / 2) * 2;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int STEP_W   = $clog2(DIV_STEPS + 1);

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
   localparam logic [WHITE_W-1:0]  WHITE_RESET = 13'd3500;
   localparam logic [BLACK_W-1:0]  BLACK_RESET = 12'd500;
   localparam logic [SAMPLE_W-1:0] REF_MARGIN  = 12'd100;
   localparam logic [THR_W-1:0]    THR_RESET   = 9'd128;

   typedef enum logic [1:0] {
      OP_MEASURE = 2'd0,
      OP_WHITE   = 2'd1,
      OP_BLACK   = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHTS   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   typedef struct packed {
      logic [WHITE_W-1:0] white;
      logic [BLACK_W-1:0] black;
   } ref_type;

   typedef struct packed {
      logic               start;
      logic               neg;
      logic [DIV_W-1:0]   mag;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [ERROR_W-1:0] result;
   } div_rsp_type;

endpackage

// ----- src/lsc_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
// standalone, no package dependency

module lsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/lsc_divider.sv -----
// signed mean divider: magnitude divided by on-channel count, two quotient bits a cycle
// depends on lsc_pkg

module lsc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  lsc_pkg::div_req_type req,
   output lsc_pkg::div_rsp_type rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [lsc_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [lsc_pkg::DIV_W-1:0]    num_ff, num_in;
   logic [lsc_pkg::DIV_W-1:0]    quot_ff, quot_in;
   logic [lsc_pkg::COUNT_W-1:0]  rem_ff, rem_in;
   logic [lsc_pkg::COUNT_W-1:0]  div_ff, div_in;
   logic                         neg_ff, neg_in;

   logic [lsc_pkg::COUNT_W:0]    r1, r2;
   logic [lsc_pkg::COUNT_W-1:0]  r1s, r2s;
   logic                         ge1, ge2;

   // two restoring steps; remainder stays below the divisor
   always_comb begin
      r1  = {rem_ff, num_ff[lsc_pkg::DIV_W-1]};
      ge1 = r1 >= {1'b0, div_ff};
      r1s = ge1 ? lsc_pkg::COUNT_W'(r1 - {1'b0, div_ff}) : lsc_pkg::COUNT_W'(r1);
      r2  = {r1s, num_ff[lsc_pkg::DIV_W-2]};
      ge2 = r2 >= {1'b0, div_ff};
      r2s = ge2 ? lsc_pkg::COUNT_W'(r2 - {1'b0, div_ff}) : lsc_pkg::COUNT_W'(r2);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = req.mag;
         quot_in = '0;
         rem_in  = '0;
         div_in  = req.divisor;
         neg_in  = req.neg;
      end else if (busy_ff) begin
         num_in  = {num_ff[lsc_pkg::DIV_W-3:0], 2'b00};
         quot_in = {quot_ff[lsc_pkg::DIV_W-3:0], ge1, ge2};
         rem_in  = r2s;
         step_in = step_ff + 1'b1;
         if (step_ff == lsc_pkg::STEP_W'(lsc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
   end

   // truncation toward zero: divide magnitudes, then restore the sign
   assign rsp.done   = done_ff;
   assign rsp.result = neg_ff ? lsc_pkg::ERROR_W'(16'd0 - quot_ff[lsc_pkg::ERROR_W-1:0])
                              : quot_ff[lsc_pkg::ERROR_W-1:0];

endmodule

// ----- src/line_sensor_centroid.sv -----
// eight-channel line sensor: per-channel calibration and weighted line centroid
// depends on lsc_pkg, lsc_ram and lsc_divider
//
// usage:
//  req_ channel carries one frame: an opcode and eight raw samples. measure marks
//  each channel on the line against its white/black references and threshold;
//  calibrate-white / calibrate-black store the frame as references, pushing the
//  other 100 counts off if they cross. every beat on req_ gives one beat on rsp_.
//  csr_ port writes threshold (index 0) and packed channel weights (index 1); the
//  user must write it only while the block is idle; the block does not enforce it.
// sequence:
//  references sit in one ram, read and written back one channel a cycle during
//  the scan. a measure with any channel on then runs the mean through a divider
//  at two quotient bits a cycle; the done state then loads the output register.
//  one frame is in work at a time.
// reset: references read as 3500/500 until written (per-channel valid bits),
//  held error 0, threshold 128, weights 0.
// stall: the result waits in the output register while the next frame is taken;
//  that frame's result waits in the done state, req_stall high, until it frees.

module line_sensor_centroid (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [11:0] req_sample_0,
   input  logic [11:0] req_sample_1,
   input  logic [11:0] req_sample_2,
   input  logic [11:0] req_sample_3,
   input  logic [11:0] req_sample_4,
   input  logic [11:0] req_sample_5,
   input  logic [11:0] req_sample_6,
   input  logic [11:0] req_sample_7,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_line_bits,
   output logic [3:0]  rsp_on_count,
   output logic signed [15:0] rsp_position_error,
   output logic        rsp_line_seen,
   output logic        rsp_all_on,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int CH  = lsc_pkg::CHANNELS;
   localparam int IW  = lsc_pkg::CH_IDX_W;
   localparam int REF_W = $bits(lsc_pkg::ref_type);

   lsc_pkg::state_type             state_ff, state_in;
   lsc_pkg::op_type                op_ff, op_in;
   logic [lsc_pkg::SAMPLE_W-1:0]   sample_ff [CH];
   logic [lsc_pkg::SAMPLE_W-1:0]   sample_in [CH];
   logic [lsc_pkg::SAMPLE_W-1:0]   port_samples [lsc_pkg::PORT_CHANNELS];
   logic [lsc_pkg::CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                           comp_act_ff, comp_act_in;
   logic [IW-1:0]                  comp_ch_ff, comp_ch_in;
   logic [7:0]                     bits_ff, bits_in;
   logic [lsc_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic signed [lsc_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [CH-1:0]                  ref_valid_ff, ref_valid_in;
   logic [lsc_pkg::THR_W-1:0]      thr_ff, thr_in;
   logic [lsc_pkg::WEIGHTS_W-1:0]  weights_ff, weights_in;
   logic [lsc_pkg::ERROR_W-1:0]    held_ff, held_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_bits_ff, rsp_bits_in;
   logic [lsc_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [lsc_pkg::ERROR_W-1:0]    rsp_error_ff, rsp_error_in;
   logic                           rsp_seen_ff, rsp_seen_in;
   logic                           rsp_all_ff, rsp_all_in;

   logic                           rd_en;
   logic [IW-1:0]                  rd_addr;
   logic [REF_W-1:0]               rd_data;
   logic                           wr_en;
   lsc_pkg::ref_type               rd_ref, wr_ref;

   lsc_pkg::div_req_type           div_req;
   lsc_pkg::div_rsp_type           div_rsp;

   // per-channel datapath
   logic [lsc_pkg::WHITE_W-1:0]    w_ref;
   logic [lsc_pkg::BLACK_W-1:0]    b_ref;
   logic [lsc_pkg::SAMPLE_W-1:0]   raw;
   logic [lsc_pkg::WHITE_W-1:0]    span, d_clamp;
   logic [lsc_pkg::SAMPLE_W-1:0]   d_raw;
   logic [21:0]                    lhs, rhs;
   logic                           degenerate, ch_on;
   logic signed [7:0]              weight;
   logic [lsc_pkg::SUM_W-1:0]      sum_mag;

   assign port_samples[0] = req_sample_0;
   assign port_samples[1] = req_sample_1;
   assign port_samples[2] = req_sample_2;
   assign port_samples[3] = req_sample_3;
   assign port_samples[4] = req_sample_4;
   assign port_samples[5] = req_sample_5;
   assign port_samples[6] = req_sample_6;
   assign port_samples[7] = req_sample_7;

   lsc_ram #(
      .WIDTH (REF_W),
      .DEPTH (CH)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (comp_ch_ff),
      .wr_data (wr_ref),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lsc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rd_en   = (state_ff == lsc_pkg::ST_SCAN) && (rd_cnt_ff < lsc_pkg::CNT_W'(CH));
   assign rd_addr = rd_cnt_ff[IW-1:0];
   assign rd_ref  = rd_data;

   // unwritten entries read as the reset references
   always_comb begin
      w_ref = ref_valid_ff[comp_ch_ff] ? rd_ref.white : lsc_pkg::WHITE_RESET;
      b_ref = ref_valid_ff[comp_ch_ff] ? rd_ref.black : lsc_pkg::BLACK_RESET;
      raw   = sample_ff[comp_ch_ff] & lsc_pkg::SAMPLE_MASK;

      degenerate = w_ref <= {1'b0, b_ref};
      span  = w_ref - {1'b0, b_ref};
      d_raw = (raw > b_ref) ? raw - b_ref : '0;
      d_clamp = ({1'b0, d_raw} > span) ? span : {1'b0, d_raw};
      lhs   = {1'b0, d_clamp, 8'h00};
      rhs   = 22'(thr_ff) * 22'(span);
      ch_on = degenerate ? (thr_ff != '0) : (lhs < rhs);
      weight = $signed(weights_ff[{comp_ch_ff, 3'b000} +: 8]);

      wr_ref = lsc_pkg::ref_type'{white: w_ref, black: b_ref};
      wr_en  = 1'b0;
      case (op_ff)
         lsc_pkg::OP_WHITE: begin
            wr_en        = comp_act_ff;
            wr_ref.white = {1'b0, raw};
            if (b_ref >= raw) begin
               wr_ref.black = (raw > lsc_pkg::REF_MARGIN) ? raw - lsc_pkg::REF_MARGIN : '0;
            end
         end
         lsc_pkg::OP_BLACK: begin
            wr_en        = comp_act_ff;
            wr_ref.black = raw;
            if (w_ref <= {1'b0, raw}) begin
               wr_ref.white = {1'b0, raw} + {1'b0, lsc_pkg::REF_MARGIN};
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase

      sum_mag = sum_ff[lsc_pkg::SUM_W-1] ? lsc_pkg::SUM_W'(-sum_ff) : lsc_pkg::SUM_W'(sum_ff);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sample_in    = sample_ff;
      rd_cnt_in    = rd_cnt_ff;
      comp_act_in  = 1'b0;
      comp_ch_in   = comp_ch_ff;
      bits_in      = bits_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      ref_valid_in = ref_valid_ff;
      thr_in       = thr_ff;
      weights_in   = weights_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_bits_in  = rsp_bits_ff;
      rsp_count_in = rsp_count_ff;
      rsp_error_in = rsp_error_ff;
      rsp_seen_in  = rsp_seen_ff;
      rsp_all_in   = rsp_all_ff;
      div_req      = '0;

      if (csr_write) begin
         case (csr_index)
            lsc_pkg::CSR_THRESHOLD: thr_in     = csr_data[lsc_pkg::THR_W-1:0];
            lsc_pkg::CSR_WEIGHTS:   weights_in = csr_data;
            default:                thr_in     = thr_ff;
         endcase
      end

      if (wr_en) begin
         ref_valid_in[comp_ch_ff] = 1'b1;
      end

      if (comp_act_ff && (op_ff == lsc_pkg::OP_MEASURE) && ch_on) begin
         bits_in  = bits_ff | (8'd1 << comp_ch_ff);
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + lsc_pkg::SUM_W'(weight);
      end

      case (state_ff)
         lsc_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in = lsc_pkg::op_type'(req_opcode);
               for (int i = 0; i < CH; i++) begin
                  sample_in[i] = port_samples[i];
               end
               rd_cnt_in = '0;
               bits_in   = '0;
               count_in  = '0;
               sum_in    = '0;
               state_in  = lsc_pkg::ST_SCAN;
            end
         end
         lsc_pkg::ST_SCAN: begin
            if (rd_en) begin
               rd_cnt_in   = rd_cnt_ff + 1'b1;
               comp_act_in = 1'b1;
               comp_ch_in  = rd_addr;
            end else if (!comp_act_ff) begin
               if ((op_ff == lsc_pkg::OP_MEASURE) && (count_ff != '0)) begin
                  div_req.start   = 1'b1;
                  div_req.neg     = sum_ff[lsc_pkg::SUM_W-1];
                  div_req.mag     = lsc_pkg::DIV_W'({sum_mag, 8'h00});
                  div_req.divisor = count_ff;
                  state_in        = lsc_pkg::ST_DIVIDE;
               end else begin
                  state_in = lsc_pkg::ST_DONE;
               end
            end
         end
         lsc_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               held_in  = div_rsp.result;
               state_in = lsc_pkg::ST_DONE;
            end
         end
         lsc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = bits_ff;
               rsp_count_in = count_ff;
               rsp_error_in = held_ff;
               rsp_seen_in  = count_ff != '0;
               rsp_all_in   = (op_ff == lsc_pkg::OP_MEASURE) &&
                              (count_ff >= lsc_pkg::COUNT_W'(CH));
               state_in     = lsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsc_pkg::ST_IDLE;
         comp_act_ff  <= 1'b0;
         rd_cnt_ff    <= '0;
         ref_valid_ff <= '0;
         thr_ff       <= lsc_pkg::THR_RESET;
         weights_ff   <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         comp_act_ff  <= comp_act_in;
         rd_cnt_ff    <= rd_cnt_in;
         ref_valid_ff <= ref_valid_in;
         thr_ff       <= thr_in;
         weights_ff   <= weights_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      sample_ff    <= sample_in;
      comp_ch_ff   <= comp_ch_in;
      bits_ff      <= bits_in;
      count_ff     <= count_in;
      sum_ff       <= sum_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_count_ff <= rsp_count_in;
      rsp_error_ff <= rsp_error_in;
      rsp_seen_ff  <= rsp_seen_in;
      rsp_all_ff   <= rsp_all_in;
   end

   assign req_stall          = state_ff != lsc_pkg::ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_bits      = rsp_bits_ff;
   assign rsp_on_count       = rsp_count_ff;
   assign rsp_position_error = $signed(rsp_error_ff);
   assign rsp_line_seen      = rsp_seen_ff;
   assign rsp_all_on         = rsp_all_ff;

endmodule

// ----- src/lsc_checker.sv -----
// port-level checks for line_sensor_centroid, attached by bind
// depends on lsc_pkg and the top level's port names

module lsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_line_bits,
   input logic [3:0]  rsp_on_count,
   input logic [15:0] rsp_position_error,
   input logic        rsp_line_seen,
   input logic        rsp_all_on
);

   // count agrees with the bitmap
   a_count_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_on_count == 4'($countones(rsp_line_bits)))
      else $error("on_count does not match line_bits");

   a_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_seen == (rsp_on_count != 4'd0))
      else $error("line_seen does not match on_count");

   a_all_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_on |-> rsp_on_count == 4'(lsc_pkg::CHANNELS))
      else $error("all_on with channels off");

   // one frame in work: busy right after an accepted beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after a beat");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position_error)
         && $stable(rsp_line_bits))
      else $error("stalled result changed");

endmodule

bind line_sensor_centroid lsc_checker u_lsc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_line_bits      (rsp_line_bits),
   .rsp_on_count       (rsp_on_count),
   .rsp_position_error (rsp_position_error),
   .rsp_line_seen      (rsp_line_seen),
   .rsp_all_on         (rsp_all_on)
);
